@@ sv/idtfi_pkg.sv @@
// ----------------------------------------------------------------------------
// idtfi_pkg
// Types and codes shared by the identifier table find-or-insert block.
// ----------------------------------------------------------------------------
package idtfi_pkg;

    localparam int ID_W       = 64;
    localparam int SLOT_OUT_W = 6;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // request transaction
    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] group_id;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [STATUS_W-1:0]   status;
    } t_out_item;

    // control part of the search token that walks the cell chain
    typedef struct packed {
        logic valid;
        logic action;
        logic found;
    } t_tok_ctl;

endpackage

@@ sv/idtfi_cell.sv @@
// ----------------------------------------------------------------------------
// idtfi_cell
// One table slot: holds a stored identifier, compares it against the search
// token passing by, and registers the token on its way to the next cell.
// ----------------------------------------------------------------------------
module idtfi_cell #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [idtfi_pkg::ID_W-1:0] i_wr_id,
    input  idtfi_pkg::t_tok_ctl      i_ctl,
    input  logic [idtfi_pkg::ID_W-1:0] i_key,
    input  logic [IDX_W-1:0]         i_slot,
    input  logic [CNT_W-1:0]         i_left,
    output idtfi_pkg::t_tok_ctl      o_ctl,
    output logic [idtfi_pkg::ID_W-1:0] o_key,
    output logic [IDX_W-1:0]         o_slot,
    output logic [CNT_W-1:0]         o_left
);
    import idtfi_pkg::*;

    logic [ID_W-1:0]  r_id;
    t_tok_ctl         r_ctl;
    t_tok_ctl         n_ctl;
    logic [ID_W-1:0]  r_key;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] n_slot;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;
    logic             w_occupied;
    logic             w_hit;

    // slot is in use while the token still has occupied slots ahead of it
    assign w_occupied = (i_left != '0);
    assign w_hit      = i_ctl.valid && !i_ctl.found && w_occupied && (r_id == i_key);

    always_comb begin
        n_ctl  = i_ctl;
        n_slot = i_slot;
        if (w_hit) begin
            n_ctl.found = 1'b1;
            n_slot      = IDX_W'(CELL_IDX);
        end
        n_left = w_occupied ? (i_left - CNT_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id <= i_wr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.action <= n_ctl.action;
        r_ctl.found  <= n_ctl.found;
        r_key        <= i_key;
        r_slot       <= n_slot;
        r_left       <= n_left;
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_slot = r_slot;
    assign o_left = r_left;

endmodule

@@ sv/id_table_find_or_insert_unit.sv @@
// ----------------------------------------------------------------------------
// id_table_find_or_insert_unit
// Identifier table with find and find-or-insert, built as a chain of slot
// cells that a search token walks through one cell per cycle.
// ----------------------------------------------------------------------------
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+------------------------
//  request  | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//  result   | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
//  One request is in flight at a time; between acceptance and the next
//  acceptance the token crosses the cell chain, is captured, and is then
//  settled and loaded into the output register as the result.
//  A stalled result holds the block in its final step until the output
//  register frees; the next request is taken while a result waits.
//  Reset clears the entry count; stored identifiers need no clearing.
// ----------------------------------------------------------------------------
module id_table_find_or_insert_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  idtfi_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output idtfi_pkg::t_out_item o_out_data
);
    import idtfi_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;

    t_tok_ctl         w_ctl  [0:TABLE_DEPTH];
    logic [ID_W-1:0]  w_key  [0:TABLE_DEPTH];
    logic [IDX_W-1:0] w_slot [0:TABLE_DEPTH];
    logic [CNT_W-1:0] w_left [0:TABLE_DEPTH];

    t_tok_ctl         r_done_ctl;
    logic [ID_W-1:0]  r_done_key;
    logic [IDX_W-1:0] r_done_slot;

    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_accept;
    logic             w_out_free;
    logic             w_load;
    logic             w_wr;
    logic [STATUS_W-1:0] w_status;
    logic [IDX_W-1:0] w_res_slot;
    logic [EXT_W-1:0] w_res_ext;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_DONE) && w_out_free;

    // token entering the chain
    assign w_ctl[0]  = t_tok_ctl'{valid: w_accept, action: i_in_data.action, found: 1'b0};
    assign w_key[0]  = i_in_data.group_id;
    assign w_slot[0] = '0;
    assign w_left[0] = r_count;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        idtfi_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr_en (w_wr && (r_count == CNT_W'(k))),
            .i_wr_id (r_done_key),
            .i_ctl   (w_ctl[k]),
            .i_key   (w_key[k]),
            .i_slot  (w_slot[k]),
            .i_left  (w_left[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_key   (w_key[k+1]),
            .o_slot  (w_slot[k+1]),
            .o_left  (w_left[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_ctl[TABLE_DEPTH].valid) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // settle the outcome of the captured token
    always_comb begin
        w_wr       = 1'b0;
        w_res_slot = '0;
        if (r_done_ctl.found) begin
            w_status   = ST_FOUND;
            w_res_slot = r_done_slot;
        end else if (!r_done_ctl.action) begin
            w_status   = ST_NOT_FOUND;
        end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
            w_status   = ST_FULL;
        end else begin
            w_status   = ST_ADDED;
            w_res_slot = IDX_W'(r_count);
            w_wr       = w_load;
        end
        w_res_ext = EXT_W'(w_res_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_ctl[TABLE_DEPTH].valid) begin
            r_done_ctl  <= w_ctl[TABLE_DEPTH];
            r_done_key  <= w_key[TABLE_DEPTH];
            r_done_slot <= w_slot[TABLE_DEPTH];
        end
        if (w_load) begin
            r_out_data.slot_index <= w_res_ext[SLOT_OUT_W-1:0];
            r_out_data.status     <= w_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/idtfi_checker.sv @@
// ----------------------------------------------------------------------------
// idtfi_checker
// Port-level checks for the identifier table find-or-insert block.
// ----------------------------------------------------------------------------
module idtfi_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  idtfi_pkg::t_in_item  i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  idtfi_pkg::t_out_item o_out_data
);
    import idtfi_pkg::*;

    // hold a stalled request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled request changed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request in flight: an accepted transaction blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // misses and full errors carry slot zero
    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NOT_FOUND ||
                        o_out_data.status == ST_FULL) |-> o_out_data.slot_index == '0)
        else $error("nonzero slot on miss or full");

    // drop results across reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");

endmodule

bind id_table_find_or_insert_unit idtfi_checker u_idtfi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks id_table_find_or_insert_unit against a table predictor. A directed
// run covers the empty, partly filled and full table; random traffic then
// fills the table and keeps hitting stored, near-miss and unknown identifiers.
// ----------------------------------------------------------------------------
module testbench;
    import idtfi_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 2);
    localparam int LONG_HOLD     = 600;
    localparam int NUM_ITEMS     = 1900;
    localparam int MAX_PRINTS    = 50;

    localparam logic ACT_FIND   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam int STALL_NONE     = 0;
    localparam int STALL_RANDOM   = 1;
    localparam int STALL_PERIODIC = 2;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    t_in_item        request_queue[$];
    t_out_item       pending_results[$];
    logic [ID_W-1:0] known_ids[$];
    logic [ID_W-1:0] table_ids[TABLE_DEPTH];
    int unsigned     table_count   = 0;
    int unsigned     error_count   = 0;
    int unsigned     result_count  = 0;
    t_out_item       expected_result;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_mode;
    int unsigned next_hold_at;

    id_table_find_or_insert_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lowest matching occupied slot wins; a miss appends only on insert.
    function automatic t_out_item lookup_or_append(input t_in_item req);
        t_out_item res;
        int s;
        res.slot_index = '0;
        res.status     = ST_NOT_FOUND;
        for (s = 0; s < table_count; s++) begin
            if (table_ids[s] == req.group_id) begin
                res.slot_index = SLOT_OUT_W'(s);
                res.status     = ST_FOUND;
                return res;
            end
        end
        if (req.action == ACT_INSERT) begin
            if (table_count >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                table_ids[table_count] = req.group_id;
                res.slot_index         = SLOT_OUT_W'(table_count);
                res.status             = ST_ADDED;
                table_count++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic add_request(input logic act, input logic [ID_W-1:0] id);
        t_in_item req;
        req.action   = act;
        req.group_id = id;
        request_queue.push_back(req);
    endtask

    function automatic logic [ID_W-1:0] fresh_id();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] pick_known();
        return known_ids[$urandom_range(0, known_ids.size() - 1)];
    endfunction

    // Sender: bursts of random length, random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (request_queue.size() != 0) begin
                in_data  <= request_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall modes, plus a long hold-off now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            mode_left    <= 0;
            stall_mode   <= STALL_NONE;
            next_hold_at <= 200;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (result_count >= next_hold_at) begin
            out_stall    <= 1'b1;
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + 900;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(STALL_NONE, STALL_PERIODIC);
                mode_left  <= $urandom_range(50, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE: begin
                    out_stall <= 1'b0;
                end
                STALL_RANDOM: begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    out_stall <= (mode_left[3:0] < 4'd5);
                end
            endcase
        end
    end

    // Monitor: check results first, then predict the transaction taken now.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                result_count <= result_count + 1;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result slot %0d status %0d",
                                              out_data.slot_index, out_data.status));
                end else begin
                    expected_result = pending_results.pop_front();
                    if (out_data.slot_index !== expected_result.slot_index) begin
                        report_mismatch($sformatf("slot_index %0d, want %0d",
                                                  out_data.slot_index,
                                                  expected_result.slot_index));
                    end
                    if (out_data.status !== expected_result.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_data.status, expected_result.status));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                pending_results.push_back(lookup_or_append(in_data));
            end
        end
    end

    initial begin
        logic [ID_W-1:0] id;
        int unsigned     sel;
        int unsigned     added;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;

        // empty table, extremes of the identifier, duplicate insert, near misses
        add_request(ACT_FIND,   '0);
        add_request(ACT_INSERT, '1);
        add_request(ACT_INSERT, '0);
        add_request(ACT_FIND,   '1);
        add_request(ACT_FIND,   '0);
        add_request(ACT_INSERT, '1);
        add_request(ACT_FIND,   64'h8000_0000_0000_0000);
        add_request(ACT_FIND,   64'h0000_0000_0000_0001);
        add_request(ACT_INSERT, 64'h0000_0000_0000_0001);
        add_request(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        add_request(ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFE);
        add_request(ACT_FIND,   64'h7FFF_FFFF_FFFF_FFFF);
        known_ids.push_back('1);
        known_ids.push_back('0);
        known_ids.push_back(64'h0000_0000_0000_0001);
        known_ids.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        added = 4;

        // fill the table with random traffic in between
        while (added < TABLE_DEPTH) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                id = fresh_id();
                add_request(ACT_INSERT, id);
                known_ids.push_back(id);
                added++;
            end else if (sel < 6) begin
                add_request(1'($urandom_range(0, 1)), pick_known());
            end else if (sel < 8) begin
                add_request(ACT_FIND, fresh_id());
            end else begin
                add_request(ACT_FIND, pick_known() ^ (64'd1 << $urandom_range(0, ID_W - 1)));
            end
        end

        // full table: insert miss, find miss, first and last slots
        add_request(ACT_INSERT, fresh_id());
        add_request(ACT_FIND,   fresh_id());
        add_request(ACT_INSERT, 64'h8000_0000_0000_0000);
        add_request(ACT_INSERT, known_ids[0]);
        add_request(ACT_FIND,   known_ids[TABLE_DEPTH - 1]);
        add_request(ACT_INSERT, known_ids[TABLE_DEPTH - 1]);

        while (request_queue.size() < NUM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                add_request(1'($urandom_range(0, 1)), pick_known());
            end else if (sel < 7) begin
                add_request(ACT_FIND, fresh_id());
            end else if (sel < 9) begin
                add_request(ACT_INSERT, fresh_id());
            end else begin
                add_request(1'($urandom_range(0, 1)),
                            pick_known() ^ (64'd1 << $urandom_range(0, ID_W - 1)));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (request_queue.size() != 0 || in_valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("id_table_find_or_insert_unit test passed");
        end else begin
            $display("id_table_find_or_insert_unit test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("id_table_find_or_insert_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/idtfi_pkg.sv
sv/idtfi_cell.sv
sv/id_table_find_or_insert_unit.sv
sv/idtfi_checker.sv
dv/testbench.sv
